[rtl/silhouette_extent_profiler_macros.svh]
// Assertion macros shared by the silhouette extent profiler modules.
`ifndef SILHOUETTE_EXTENT_PROFILER_MACROS_SVH
`define SILHOUETTE_EXTENT_PROFILER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sep assertion failed");

// Next-cycle implication, checked out of reset.
`define SEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sep assertion failed");

`endif

[rtl/sep_pkg.sv]
// Shared types and constants of the silhouette extent profiler.
`default_nettype none
package sep_pkg;

    localparam int CFG_W       = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int SIDE_REG_W  = 11;
    localparam int COUNT_W     = 21;
    localparam int POS_W       = 10;
    localparam int EXTENT_W    = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_COUNT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_COUNT    = 2'd3;

    localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 11'd1024;

    typedef struct packed {
        logic pixel;
        logic col_end;
        logic frame_end;
    } sep_flags_t;

    localparam int FLAGS_W = $bits(sep_flags_t);

    typedef struct packed {
        logic [COUNT_W-1:0] start_count;
        logic [COUNT_W-1:0] end_count;
    } sep_counts_t;

    typedef struct packed {
        logic                start_found;
        logic [POS_W-1:0]    start_column;
        logic                end_found;
        logic [POS_W-1:0]    end_column;
        logic [POS_W-1:0]    widest_column;
        logic [POS_W-1:0]    widest_top;
        logic [POS_W-1:0]    widest_bottom;
        logic [EXTENT_W-1:0] widest_size;
    } sep_result_t;

endpackage
`default_nettype wire

[rtl/sep_front.sv]
// Front end: accepts pixels and tags each with its row, column and end flags.
`default_nettype none
module sep_front #(
    parameter int IDX_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             pixel,
    input  wire logic [IDX_W-1:0] w_last,
    input  wire logic [IDX_W-1:0] h_last,
    input  wire logic             q_full,
    output logic                  q_push,
    output sep_pkg::sep_flags_t   q_flags,
    output logic [IDX_W-1:0]      q_row,
    output logic [IDX_W-1:0]      q_col
);
    import sep_pkg::*;

    `include "silhouette_extent_profiler_macros.svh"

    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic             col_end;
    logic             frame_end;

    assign in_ready  = !q_full;
    assign q_push    = in_valid && !q_full;
    assign col_end   = (row_reg >= h_last);
    assign frame_end = col_end && (col_reg >= w_last);

    assign q_flags.pixel     = pixel;
    assign q_flags.col_end   = col_end;
    assign q_flags.frame_end = frame_end;
    assign q_row             = row_reg;
    assign q_col             = col_reg;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (q_push)
        begin
            if (col_end)
            begin
                row_next = '0;
                col_next = frame_end ? '0 : col_reg + IDX_W'(1);
            end
            else
            begin
                row_next = row_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    `SEP_ASSERT_NEXT(a_frame_wraps, q_push && frame_end, row_reg == '0 && col_reg == '0)

endmodule
`default_nettype wire

[rtl/sep_queue.sv]
// Short queue between the front end and the accumulator.
`default_nettype none
module sep_queue #(
    parameter int DATA_W = 23
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);
    import sep_pkg::*;

    `include "silhouette_extent_profiler_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `SEP_ASSERT_NOW(a_no_overflow, push, !full)
    `SEP_ASSERT_NOW(a_no_underflow, pop, !empty)

endmodule
`default_nettype wire

[rtl/sep_back.sv]
// Back end: running sum, start/end columns, per-column extent and result register.
`default_nettype none
module sep_back #(
    parameter int MAX_SIDE = 1024,
    parameter int IDX_W    = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    output logic                     q_pop,
    input  wire sep_pkg::sep_flags_t q_flags,
    input  wire logic [IDX_W-1:0]    q_row,
    input  wire logic [IDX_W-1:0]    q_col,
    input  wire logic [IDX_W-1:0]    h_last,
    input  wire sep_pkg::sep_counts_t counts,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sep_pkg::sep_result_t     result
);
    import sep_pkg::*;

    `include "silhouette_extent_profiler_macros.svh"

    localparam int SUM_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int CMP_W  = (SUM_W > COUNT_W) ? SUM_W : COUNT_W;
    localparam int SIZE_W = IDX_W + 1;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              start_seen_reg, start_seen_next;
    logic [IDX_W-1:0]  start_col_reg, start_col_next;
    logic              end_seen_reg, end_seen_next;
    logic [IDX_W-1:0]  end_col_reg, end_col_next;
    logic              has_reg, has_next;
    logic [IDX_W-1:0]  top_reg, top_next;
    logic [IDX_W-1:0]  bot_reg, bot_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic [IDX_W-1:0]  best_col_reg, best_col_next;
    logic [IDX_W-1:0]  best_top_reg, best_top_next;
    logic [IDX_W-1:0]  best_bot_reg, best_bot_next;
    logic              out_valid_reg, out_valid_next;
    sep_result_t       result_reg, result_next;

    logic [SUM_W-1:0]  sum_acc;
    logic              start_hit, end_hit;
    logic              cur_has;
    logic [IDX_W-1:0]  cur_top, cur_bot, ext_top, ext_bot;
    logic [SIZE_W-1:0] ext_size;
    logic              wider;

    assign q_pop = !q_empty && (!q_flags.frame_end || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        sum_acc   = sum_reg + SUM_W'(q_flags.pixel);
        start_hit = !start_seen_reg && (CMP_W'(sum_acc) > CMP_W'(counts.start_count));
        end_hit   = (start_seen_reg || start_hit) && !end_seen_reg
                    && (CMP_W'(sum_acc) > CMP_W'(counts.end_count));
        cur_has   = has_reg || q_flags.pixel;
        cur_top   = (q_flags.pixel && !has_reg) ? q_row : top_reg;
        cur_bot   = q_flags.pixel ? q_row : bot_reg;
        ext_top   = cur_has ? cur_top : h_last;
        ext_bot   = cur_has ? cur_bot : h_last;
        ext_size  = {1'b0, ext_bot} - {1'b0, ext_top} + SIZE_W'(1);
        wider     = q_flags.col_end && (ext_size > best_size_reg);

        sum_next        = sum_reg;
        start_seen_next = start_seen_reg;
        start_col_next  = start_col_reg;
        end_seen_next   = end_seen_reg;
        end_col_next    = end_col_reg;
        has_next        = has_reg;
        top_next        = top_reg;
        bot_next        = bot_reg;
        best_size_next  = best_size_reg;
        best_col_next   = best_col_reg;
        best_top_next   = best_top_reg;
        best_bot_next   = best_bot_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (q_pop)
        begin
            sum_next = sum_acc;
            if (start_hit)
            begin
                start_seen_next = 1'b1;
                start_col_next  = q_col;
            end
            if (end_hit)
            begin
                end_seen_next = 1'b1;
                end_col_next  = q_col;
            end
            has_next = cur_has;
            top_next = cur_top;
            bot_next = cur_bot;
            if (wider)
            begin
                best_size_next = ext_size;
                best_col_next  = q_col;
                best_top_next  = ext_top;
                best_bot_next  = ext_bot;
            end
            if (q_flags.col_end)
            begin
                has_next = 1'b0;
                top_next = '0;
                bot_next = '0;
            end
            if (q_flags.frame_end)
            begin
                result_next.start_found   = start_seen_next;
                result_next.start_column  = POS_W'(start_col_next);
                result_next.end_found     = end_seen_next;
                result_next.end_column    = POS_W'(end_col_next);
                result_next.widest_column = POS_W'(best_col_next);
                result_next.widest_top    = POS_W'(best_top_next);
                result_next.widest_bottom = POS_W'(best_bot_next);
                result_next.widest_size   = EXTENT_W'(best_size_next);
                out_valid_next  = 1'b1;
                sum_next        = '0;
                start_seen_next = 1'b0;
                start_col_next  = '0;
                end_seen_next   = 1'b0;
                end_col_next    = '0;
                best_size_next  = '0;
                best_col_next   = '0;
                best_top_next   = '0;
                best_bot_next   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            start_seen_reg <= 1'b0;
            start_col_reg  <= '0;
            end_seen_reg   <= 1'b0;
            end_col_reg    <= '0;
            has_reg        <= 1'b0;
            top_reg        <= '0;
            bot_reg        <= '0;
            best_size_reg  <= '0;
            best_col_reg   <= '0;
            best_top_reg   <= '0;
            best_bot_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            start_seen_reg <= start_seen_next;
            start_col_reg  <= start_col_next;
            end_seen_reg   <= end_seen_next;
            end_col_reg    <= end_col_next;
            has_reg        <= has_next;
            top_reg        <= top_next;
            bot_reg        <= bot_next;
            best_size_reg  <= best_size_next;
            best_col_reg   <= best_col_next;
            best_top_reg   <= best_top_next;
            best_bot_reg   <= best_bot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `SEP_ASSERT_NOW(a_no_result_overwrite, out_valid_reg && !out_ready && q_pop, !q_flags.frame_end)
    `SEP_ASSERT_NEXT(a_frame_gives_result, q_pop && q_flags.frame_end, out_valid_reg && sum_reg == '0)
    `SEP_ASSERT_NOW(a_end_after_start, end_seen_reg, start_seen_reg)

endmodule
`default_nettype wire

[rtl/silhouette_extent_profiler.sv]
// Top level of the silhouette extent profiler: configuration registers and wiring.
`default_nettype none
// Pixels of one frame arrive column by column, top row first, one request per
// cycle with no gaps needed while the queue is not full; the accumulator sets the
// sustained rate of one pixel per clock unless a frame-end pixel waits on a held
// result. A four-entry queue decouples pixel intake from the accumulator, and the
// frame result sits in its own output register, so intake keeps running while a
// result waits. The result request is raised from the output register after the
// last pixel of a frame has passed through the queue. Width and height are taken
// as 1 when written 0 and as MAX_SIDE when above it. A register write takes effect
// on the next pixel, and a row or column already past a smaller size ends the
// column or frame there; write registers only while no request is queued.
module silhouette_extent_profiler #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sep_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sep_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            pixel,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 start_found,
    output logic [sep_pkg::POS_W-1:0]            start_column,
    output logic                                 end_found,
    output logic [sep_pkg::POS_W-1:0]            end_column,
    output logic [sep_pkg::POS_W-1:0]            widest_column,
    output logic [sep_pkg::POS_W-1:0]            widest_top,
    output logic [sep_pkg::POS_W-1:0]            widest_bottom,
    output logic [sep_pkg::EXTENT_W-1:0]         widest_size
);
    import sep_pkg::*;

    localparam int IDX_W   = $clog2(MAX_SIDE);
    localparam int ENTRY_W = FLAGS_W + 2 * IDX_W;

    function automatic logic [IDX_W-1:0] side_last(input logic [SIDE_REG_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (int'(v) > MAX_SIDE)
        begin
            r = IDX_W'(MAX_SIDE - 1);
        end
        else
        begin
            r = IDX_W'(v - SIDE_REG_W'(1));
        end
        return r;
    endfunction

    logic [IDX_W-1:0] w_last_reg, h_last_reg;
    sep_counts_t      counts_reg;

    logic              q_full, q_empty, q_push, q_pop;
    sep_flags_t        f_flags, b_flags;
    logic [IDX_W-1:0]  f_row, f_col, b_row, b_col;
    logic [ENTRY_W-1:0] b_entry;
    sep_result_t       result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg             <= side_last(SIDE_RESET);
            h_last_reg             <= side_last(SIDE_RESET);
            counts_reg.start_count <= '0;
            counts_reg.end_count   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  w_last_reg <= side_last(cfg_data[SIDE_REG_W-1:0]);
                CFG_IMAGE_HEIGHT: h_last_reg <= side_last(cfg_data[SIDE_REG_W-1:0]);
                CFG_START_COUNT:  counts_reg.start_count <= cfg_data[COUNT_W-1:0];
                CFG_END_COUNT:    counts_reg.end_count <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    sep_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel    (pixel),
        .w_last   (w_last_reg),
        .h_last   (h_last_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_flags  (f_flags),
        .q_row    (f_row),
        .q_col    (f_col)
    );

    sep_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_flags, f_row, f_col}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (b_entry),
        .empty     (q_empty)
    );

    assign b_flags = b_entry[ENTRY_W-1 -: FLAGS_W];
    assign b_row   = b_entry[2*IDX_W-1 -: IDX_W];
    assign b_col   = b_entry[IDX_W-1:0];

    sep_back #(
        .MAX_SIDE (MAX_SIDE),
        .IDX_W    (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_flags   (b_flags),
        .q_row     (b_row),
        .q_col     (b_col),
        .h_last    (h_last_reg),
        .counts    (counts_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign start_found   = result.start_found;
    assign start_column  = result.start_column;
    assign end_found     = result.end_found;
    assign end_column    = result.end_column;
    assign widest_column = result.widest_column;
    assign widest_top    = result.widest_top;
    assign widest_bottom = result.widest_bottom;
    assign widest_size   = result.widest_size;

endmodule
`default_nettype wire

[tb/tb_silhouette_extent_profiler.sv]
// Self-checking testbench for the silhouette extent profiler: frames of pixels, predicted results.
module tb_silhouette_extent_profiler;
    timeunit 1ns;
    timeprecision 1ps;

    import sep_pkg::*;

    localparam logic [SIDE_REG_W-1:0] MAX_SIDE    = 11'd1024;
    localparam int                    CYCLE_LIMIT = 500000;
    localparam int                    DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [SIDE_REG_W-1:0] w;
        logic [SIDE_REG_W-1:0] h;
        logic [COUNT_W-1:0]    sc;
        logic [COUNT_W-1:0]    ec;
        logic [5:0]            npix;
        logic [31:0]           pix;
        logic                  counts;
        logic                  listed;
        sep_result_t           res;
    } frame_case_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   pixel = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    sep_result_t            got;

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int frames_expected = 0;
    int small_pixels = 0;

    // predictor copy of registers and frame state
    logic [SIDE_REG_W-1:0] width_reg = SIDE_RESET;
    logic [SIDE_REG_W-1:0] height_reg = SIDE_RESET;
    logic [COUNT_W-1:0]    start_thr = '0;
    logic [COUNT_W-1:0]    end_thr = '0;
    logic [POS_W-1:0]      pos_col = '0;
    logic [POS_W-1:0]      pos_row = '0;
    logic [COUNT_W-1:0]    px_total = '0;
    logic                  start_hit = 1'b0;
    logic [POS_W-1:0]      start_at = '0;
    logic                  end_hit = 1'b0;
    logic [POS_W-1:0]      end_at = '0;
    logic                  col_lit = 1'b0;
    logic [POS_W-1:0]      col_first = '0;
    logic [POS_W-1:0]      col_last = '0;
    logic [EXTENT_W-1:0]   top_extent = '0;
    logic [POS_W-1:0]      top_col = '0;
    logic [POS_W-1:0]      top_first = '0;
    logic [POS_W-1:0]      top_last = '0;

    sep_result_t expected_frames[$];
    bit          use_listed = 1'b0;
    sep_result_t listed_res = '0;
    frame_case_t dir_frames [0:4];

    silhouette_extent_profiler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .start_found  (got.start_found),
        .start_column (got.start_column),
        .end_found    (got.end_found),
        .end_column   (got.end_column),
        .widest_column(got.widest_column),
        .widest_top   (got.widest_top),
        .widest_bottom(got.widest_bottom),
        .widest_size  (got.widest_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= out_idle_pct);
    end

    function automatic logic [SIDE_REG_W-1:0] side_limit(input logic [SIDE_REG_W-1:0] v);
        if (v == '0)
            return 11'd1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    // advances the frame state by one pixel; returns 1 when the frame closes
    function automatic bit profile_pixel(input logic p, output sep_result_t res);
        logic [SIDE_REG_W-1:0] w_eff;
        logic [SIDE_REG_W-1:0] h_eff;
        logic [EXTENT_W-1:0]   first;
        logic [EXTENT_W-1:0]   last;
        logic [EXTENT_W-1:0]   extent;
        w_eff = side_limit(width_reg);
        h_eff = side_limit(height_reg);
        res = '0;
        px_total = px_total + COUNT_W'(p);
        if (!start_hit && px_total > start_thr)
        begin
            start_hit = 1'b1;
            start_at = pos_col;
        end
        if (start_hit && !end_hit && px_total > end_thr)
        begin
            end_hit = 1'b1;
            end_at = pos_col;
        end
        if (p)
        begin
            if (!col_lit)
                col_first = pos_row;
            col_last = pos_row;
            col_lit = 1'b1;
        end
        if ({1'b0, pos_row} + 11'd1 < h_eff)
        begin
            pos_row++;
            return 1'b0;
        end
        // empty column sits on the bottom row with extent one
        if (col_lit)
        begin
            first = {1'b0, col_first};
            last = {1'b0, col_last};
        end
        else
        begin
            first = h_eff - 11'd1;
            last = h_eff - 11'd1;
        end
        extent = last - first + 11'd1;
        if (extent > top_extent)
        begin
            top_extent = extent;
            top_col = pos_col;
            top_first = first[POS_W-1:0];
            top_last = last[POS_W-1:0];
        end
        pos_row = '0;
        col_lit = 1'b0;
        col_first = '0;
        col_last = '0;
        if ({1'b0, pos_col} + 11'd1 < w_eff)
        begin
            pos_col++;
            return 1'b0;
        end
        res.start_found = start_hit;
        res.start_column = start_hit ? start_at : '0;
        res.end_found = end_hit;
        res.end_column = end_hit ? end_at : '0;
        res.widest_column = top_col;
        res.widest_top = top_first;
        res.widest_bottom = top_last;
        res.widest_size = top_extent;
        pos_col = '0;
        px_total = '0;
        start_hit = 1'b0;
        start_at = '0;
        end_hit = 1'b0;
        end_at = '0;
        top_extent = '0;
        top_col = '0;
        top_first = '0;
        top_last = '0;
        return 1'b1;
    endfunction

    task automatic flag_field(input string name, input logic [31:0] seen, input logic [31:0] want);
        if (seen !== want)
        begin
            $display("MISMATCH %s: got %0d, expected %0d at cycle %0d",
                     name, seen, want, cycle_count);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : pixel_monitor
        sep_result_t frame_res;
        if (rst_n && in_valid && in_ready)
        begin
            if (profile_pixel(pixel, frame_res))
            begin
                expected_frames.push_back(use_listed ? listed_res : frame_res);
                frames_expected++;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        sep_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
                flag_field("unexpected result", 1, 0);
            else
            begin
                want = expected_frames.pop_front();
                flag_field("start_found", 32'(got.start_found), 32'(want.start_found));
                flag_field("start_column", 32'(got.start_column), 32'(want.start_column));
                flag_field("end_found", 32'(got.end_found), 32'(want.end_found));
                flag_field("end_column", 32'(got.end_column), 32'(want.end_column));
                flag_field("widest_column", 32'(got.widest_column),
                           32'(want.widest_column));
                flag_field("widest_top", 32'(got.widest_top), 32'(want.widest_top));
                flag_field("widest_bottom", 32'(got.widest_bottom),
                           32'(want.widest_bottom));
                flag_field("widest_size", 32'(got.widest_size), 32'(want.widest_size));
            end
        end
    end

    task automatic send_pixel(input logic p);
        while ($urandom_range(99, 0) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_regs(input logic [SIDE_REG_W-1:0] w, input logic [SIDE_REG_W-1:0] h,
                            input logic [COUNT_W-1:0] sc, input logic [COUNT_W-1:0] ec,
                            input bit with_counts);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_W-1:0]       vals [4];
        idx[0] = CFG_IMAGE_WIDTH;
        idx[1] = CFG_IMAGE_HEIGHT;
        idx[2] = CFG_START_COUNT;
        idx[3] = CFG_END_COUNT;
        vals[0] = {10'd0, w};
        vals[1] = {10'd0, h};
        vals[2] = sc;
        vals[3] = ec;
        wait_drained(DRAIN_WAIT);
        for (int i = 0; i < (with_counts ? 4 : 2); i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
        if (with_counts)
        begin
            start_thr = sc;
            end_thr = ec;
        end
    endtask

    // kind 0: small frames, 1: widest frame (width register all ones), 2: tallest frame
    task automatic run_phase(input int kind);
        logic [SIDE_REG_W-1:0] w;
        logic [SIDE_REG_W-1:0] h;
        logic [COUNT_W-1:0]    sc;
        logic [COUNT_W-1:0]    ec;
        int  we, he, nfr, style, dens, ctop, cbot;
        bit  cempty;
        logic p;
        if (kind == 1)
        begin
            w = 11'h7FF;
            h = 11'd1;
            sc = 21'd1022 - COUNT_W'($urandom_range(2, 0));
            ec = sc + COUNT_W'($urandom_range(1, 0));
            nfr = 1;
        end
        else if (kind == 2)
        begin
            w = 11'd1;
            h = 11'h7FF;
            sc = COUNT_W'($urandom_range(3, 0));
            ec = COUNT_W'($urandom_range(3, 0));
            nfr = 1;
        end
        else
        begin
            w = SIDE_REG_W'($urandom_range(9, 0));
            h = SIDE_REG_W'($urandom_range(9, 0));
            we = int'(side_limit(w));
            he = int'(side_limit(h));
            case ($urandom_range(7, 0))
                0:
                begin
                    sc = '0;
                    ec = '0;
                end
                1:
                begin
                    sc = '1;
                    ec = '1;
                end
                2:
                begin
                    sc = COUNT_W'($urandom());
                    ec = COUNT_W'($urandom());
                end
                default:
                begin
                    sc = COUNT_W'($urandom_range(we * he, 0));
                    ec = COUNT_W'($urandom_range(we * he + 1, 0));
                end
            endcase
            nfr = $urandom_range(4, 1);
        end
        set_regs(w, h, sc, ec, 1'b1);
        we = int'(side_limit(w));
        he = int'(side_limit(h));
        for (int f = 0; f < nfr; f++)
        begin
            style = (kind == 1) ? 3 : (kind == 2) ? 4 : $urandom_range(4, 0);
            dens = $urandom_range(100, 0);
            for (int c = 0; c < we; c++)
            begin
                cempty = ($urandom_range(3, 0) == 0);
                ctop = $urandom_range(he - 1, 0);
                cbot = $urandom_range(he - 1, ctop);
                for (int r = 0; r < he; r++)
                begin
                    case (style)
                        0: p = ($urandom_range(99, 0) < dens);
                        1: p = !cempty && r >= ctop && r <= cbot;
                        2: p = 1'b0;
                        3: p = 1'b1;
                        default: p = (r == 0 || r == he - 1);
                    endcase
                    send_pixel(p);
                    if (kind == 0)
                        small_pixels++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int k;
        // counts left at reset value on the first frame
        dir_frames[0] = '{11'd2, 11'd3, 21'd0, 21'd0, 6'd6, 32'h3A, 1'b0, 1'b1,
                          '{1'b1, 10'd0, 1'b1, 10'd0, 10'd1, 10'd0, 10'd2, 11'd3}};
        // zero sizes fold to a single pixel
        dir_frames[1] = '{11'd0, 11'd0, 21'd0, 21'd0, 6'd1, 32'h0, 1'b1, 1'b1,
                          '{1'b0, 10'd0, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 11'd1}};
        // all empty columns
        dir_frames[2] = '{11'd2, 11'd4, 21'd2, 21'd3, 6'd8, 32'h0, 1'b1, 1'b1,
                          '{1'b0, 10'd0, 1'b0, 10'd0, 10'd0, 10'd3, 10'd3, 11'd1}};
        // start and end on the same pixel
        dir_frames[3] = '{11'd3, 11'd2, 21'd1, 21'd1, 6'd6, 32'h39, 1'b1, 1'b0, '0};
        // start found, end never reached
        dir_frames[4] = '{11'd2, 11'd2, 21'd0, 21'd5, 6'd4, 32'h9, 1'b1, 1'b1,
                          '{1'b1, 10'd0, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 11'd1}};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_idle_pct = 28;
        out_idle_pct = 83;
        for (int i = 0; i < 5; i++)
        begin
            set_regs(dir_frames[i].w, dir_frames[i].h, dir_frames[i].sc, dir_frames[i].ec,
                     dir_frames[i].counts);
            use_listed = dir_frames[i].listed;
            listed_res = dir_frames[i].res;
            for (int j = 0; j < dir_frames[i].npix; j++)
                send_pixel(dir_frames[i].pix[j]);
        end
        wait_drained(DRAIN_WAIT);
        use_listed = 1'b0;

        k = 0;
        while (small_pixels < 1850 || frames_expected < 48)
        begin
            if (small_pixels < 617)
            begin
                in_idle_pct = 28;
                out_idle_pct = 83;
            end
            else if (small_pixels < 1234)
            begin
                in_idle_pct = 83;
                out_idle_pct = 28;
            end
            else
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            run_phase(k == 3 ? 1 : (k == 8 ? 2 : 0));
            k++;
        end

        wait_drained(20);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/sep_pkg.sv
rtl/sep_front.sv
rtl/sep_queue.sv
rtl/sep_back.sv
rtl/silhouette_extent_profiler.sv
tb/tb_silhouette_extent_profiler.sv
